>>> hw/rtl/ctf_pkg.sv
// Shared constants and types for the contour fingertip finder.
package ctf_pkg;

    localparam int COORD_BITS   = 12;
    localparam int MAX_TIPS     = 8;
    localparam int DIST_BITS    = 2 * COORD_BITS + 1;
    localparam int COUNT_BITS   = $clog2(MAX_TIPS + 1);
    localparam int HOLD_BITS    = 8;
    localparam int CFG_BITS     = 12;
    localparam int TIP_NUM_BITS = 4;
    localparam int S_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * COORD_BITS + TIP_NUM_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic [HOLD_BITS-1:0] HOLD_LIMIT_RESET = 8'd40;
    localparam logic [CFG_BITS-1:0]  MIN_GAP_RESET    = 12'd20;

    typedef enum logic [1:0] {
        CFG_CENTER_X   = 2'd0,
        CFG_CENTER_Y   = 2'd1,
        CFG_HOLD_LIMIT = 2'd2,
        CFG_MIN_GAP    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DECIDE
    } state_t;

    // Point held alongside the distance pipeline
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  first;
    } point_t;

    // Control fed to the tip cell row
    typedef struct packed {
        logic                  shift;
        logic [COORD_BITS-1:0] col;
        logic [CFG_BITS-1:0]   gap;
    } chain_ctrl_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> hw/rtl/contour_fingertip_finder_top.sv
// Top level of the contour fingertip finder.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    contour point, first-point flag
//  m_       out  m_tvalid/m_tready    fingertip, list position, dropped flag
//  cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// Sequence: each point passes a squaring state, which squares the centre offsets,
// and a decision state, which sums, compares with the held maximum and runs the
// tip cell row. The next point is taken in the decision state, so the squaring
// multipliers hold off the next point while the last one is squared.
// Reset: synchronous, active low; no clearing pass, tip cells are gated by
// the tip count.
// Stalls: a result waiting in the output register holds the decision cycle
// until it is taken; config writes are always accepted.
module contour_fingertip_finder_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: point_x, point_y
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ctf_pkg::S_DATA_BITS-1:0] s_tdata,
    // s_tuser: first_point
    input  logic                            s_tuser,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [ctf_pkg::CFG_BITS-1:0]    cfg_data,
    // m_tdata: tip_x, tip_y, tip_number
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ctf_pkg::M_DATA_BITS-1:0] m_tdata,
    // m_tuser: tip_dropped
    output logic                            m_tuser
);

    localparam int CB = ctf_pkg::COORD_BITS;

    // configuration registers
    logic [ctf_pkg::CFG_BITS-1:0]  center_x_reg, center_y_reg, min_gap_reg;
    logic [ctf_pkg::HOLD_BITS-1:0] hold_limit_reg;

    // running state
    ctf_pkg::state_t                state_reg, state_next;
    logic [ctf_pkg::DIST_BITS-1:0]  best_distance_reg, best_distance_next;
    logic [CB-1:0]                  best_x_reg, best_x_next;
    logic [CB-1:0]                  best_y_reg, best_y_next;
    logic [ctf_pkg::HOLD_BITS-1:0]  hold_counter_reg, hold_counter_next;
    logic [ctf_pkg::COUNT_BITS-1:0] tip_count_reg, tip_count_next;

    // output register
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [CB-1:0]                    out_x_reg, out_y_reg;
    logic [ctf_pkg::TIP_NUM_BITS-1:0] out_num_reg, out_num_next;
    logic                             out_drop_reg, out_drop_next;

    // FSM outputs
    logic load, square_en, decide_go;

    // datapath
    logic [CB-1:0]                  cx, cy;
    ctf_pkg::point_t                pt_in, pt;
    logic [ctf_pkg::DIST_BITS-1:0]  sq_dist, eff_best;
    logic [ctf_pkg::HOLD_BITS-1:0]  eff_hold;
    logic [ctf_pkg::COUNT_BITS-1:0] eff_count;
    logic [ctf_pkg::HOLD_BITS:0]    hold_inc;
    logic [ctf_pkg::MAX_TIPS-1:0]   cell_en;
    ctf_pkg::chain_ctrl_t           chain_ctrl;
    logic                           gap_hit, fire, store;

    assign cx = CB'(center_x_reg);
    assign cy = CB'(center_y_reg);

    assign pt_in.x     = s_tdata[CB-1:0];
    assign pt_in.y     = s_tdata[2*CB-1:CB];
    assign pt_in.first = s_tuser;

    // config: taken on any cycle; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            hold_limit_reg <= ctf_pkg::HOLD_LIMIT_RESET;
            min_gap_reg    <= ctf_pkg::MIN_GAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ctf_pkg::CFG_CENTER_X:   center_x_reg   <= cfg_data;
                ctf_pkg::CFG_CENTER_Y:   center_y_reg   <= cfg_data;
                ctf_pkg::CFG_HOLD_LIMIT: hold_limit_reg <= cfg_data[ctf_pkg::HOLD_BITS-1:0];
                ctf_pkg::CFG_MIN_GAP:    min_gap_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ctf_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = ctf_pkg::ST_SQUARE;
            end
            ctf_pkg::ST_SQUARE: begin
                state_next = ctf_pkg::ST_DECIDE;
            end
            ctf_pkg::ST_DECIDE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = s_tvalid ? ctf_pkg::ST_SQUARE : ctf_pkg::ST_IDLE;
                end
            end
            default: state_next = ctf_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        square_en = 1'b0;
        decide_go = 1'b0;
        s_tready  = 1'b0;
        case (state_reg)
            ctf_pkg::ST_IDLE:   s_tready  = 1'b1;
            ctf_pkg::ST_SQUARE: square_en = 1'b1;
            ctf_pkg::ST_DECIDE: begin
                decide_go = !m_tvalid_reg || m_tready;
                s_tready  = decide_go;
            end
            default: ;
        endcase
        load = s_tvalid && s_tready;
    end

    ctf_dist_unit u_dist (
        .aclk    (aclk),
        .load    (load),
        .step    (square_en),
        .pt_in   (pt_in),
        .cx      (cx),
        .cy      (cy),
        .pt_out  (pt),
        .sq_dist (sq_dist)
    );

    // a first point clears the run before it is weighed
    assign eff_best  = pt.first ? '0 : best_distance_reg;
    assign eff_hold  = pt.first ? '0 : hold_counter_reg;
    assign eff_count = pt.first ? '0 : tip_count_reg;
    assign hold_inc  = {1'b0, eff_hold} + 1'b1;

    always_comb begin
        for (int i = 0; i < ctf_pkg::MAX_TIPS; i++) begin
            cell_en[i] = ctf_pkg::COUNT_BITS'(i) < eff_count;
        end
    end

    // judged point is always the held one, never the point just in
    assign chain_ctrl.col   = best_x_reg;
    assign chain_ctrl.gap   = min_gap_reg;
    assign chain_ctrl.shift = store;

    ctf_tip_chain u_chain (
        .aclk (aclk),
        .ctrl (chain_ctrl),
        .en   (cell_en),
        .hit  (gap_hit)
    );

    // decision
    always_comb begin
        best_distance_next = eff_best;
        best_x_next        = pt.first ? '0 : best_x_reg;
        best_y_next        = pt.first ? '0 : best_y_reg;
        hold_counter_next  = eff_hold;
        tip_count_next     = eff_count;
        fire               = 1'b0;
        store              = 1'b0;
        out_num_next       = '0;
        out_drop_next      = 1'b0;
        if (sq_dist > eff_best) begin
            best_distance_next = sq_dist;
            best_x_next        = pt.x;
            best_y_next        = pt.y;
        end else if (sq_dist != eff_best) begin
            if (hold_inc <= {1'b0, hold_limit_reg}) begin
                hold_counter_next = hold_inc[ctf_pkg::HOLD_BITS-1:0];
            end else begin
                hold_counter_next  = '0;
                best_distance_next = '0;
                // below the palm centre, or too near a stored tip: no result
                if (!(cy < best_y_reg) && !gap_hit) begin
                    fire = decide_go;
                    if (eff_count < ctf_pkg::COUNT_BITS'(ctf_pkg::MAX_TIPS)) begin
                        store          = decide_go;
                        out_num_next   = ctf_pkg::TIP_NUM_BITS'(eff_count);
                        tip_count_next = eff_count + 1'b1;
                    end else begin
                        out_drop_next = 1'b1;
                    end
                end
            end
        end
        m_tvalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ctf_pkg::ST_IDLE;
            best_distance_reg <= '0;
            best_x_reg        <= '0;
            best_y_reg        <= '0;
            hold_counter_reg  <= '0;
            tip_count_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (decide_go) begin
                best_distance_reg <= best_distance_next;
                best_x_reg        <= best_x_next;
                best_y_reg        <= best_y_next;
                hold_counter_reg  <= hold_counter_next;
                tip_count_reg     <= tip_count_next;
            end
        end
    end

    // result payload, loaded only when a tip is reported
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_x_reg    <= best_x_reg;
            out_y_reg    <= best_y_reg;
            out_num_reg  <= out_num_next;
            out_drop_reg <= out_drop_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ctf_pkg::M_DATA_BITS'({out_num_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_drop_reg;

endmodule

>>> hw/rtl/ctf_dist_unit.sv
// Squared distance pipeline: registered differences, then registered squares.
module ctf_dist_unit (
    input  logic                             aclk,
    input  logic                             load,
    input  logic                             step,
    input  ctf_pkg::point_t                  pt_in,
    input  logic [ctf_pkg::COORD_BITS-1:0]   cx,
    input  logic [ctf_pkg::COORD_BITS-1:0]   cy,
    output ctf_pkg::point_t                  pt_out,
    output logic [ctf_pkg::DIST_BITS-1:0]    sq_dist
);

    logic [ctf_pkg::COORD_BITS-1:0]   dx_reg, dy_reg;
    logic [2*ctf_pkg::COORD_BITS-1:0] sqx_reg, sqy_reg;
    ctf_pkg::point_t                  pt_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            dx_reg <= ctf_pkg::abs_diff(pt_in.x, cx);
            dy_reg <= ctf_pkg::abs_diff(pt_in.y, cy);
            pt_reg <= pt_in;
        end
        if (step) begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
    end

    assign sq_dist = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign pt_out  = pt_reg;

endmodule

>>> hw/rtl/ctf_tip_cell.sv
// One stored tip column with its own closeness compare.
module ctf_tip_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  ctf_pkg::chain_ctrl_t           ctrl,
    input  logic [ctf_pkg::COORD_BITS-1:0] col_in,
    input  logic                           hit_in,
    output logic [ctf_pkg::COORD_BITS-1:0] col_out,
    output logic                           hit_out
);

    logic [ctf_pkg::COORD_BITS-1:0] col_reg;
    logic [ctf_pkg::COORD_BITS-1:0] gap;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            col_reg <= col_in;
        end
    end

    assign gap     = ctf_pkg::abs_diff(ctrl.col, col_reg);
    assign hit_out = hit_in | (en & ({{ctf_pkg::CFG_BITS{1'b0}}, gap} <
                                     {{ctf_pkg::COORD_BITS{1'b0}}, ctrl.gap}));
    assign col_out = col_reg;

endmodule

>>> hw/rtl/ctf_tip_chain.sv
// Row of tip cells: new tips enter at cell 0 and push older ones along.
module ctf_tip_chain (
    input  logic                         aclk,
    input  ctf_pkg::chain_ctrl_t         ctrl,
    input  logic [ctf_pkg::MAX_TIPS-1:0] en,
    output logic                         hit
);

    logic [ctf_pkg::COORD_BITS-1:0] col_link [ctf_pkg::MAX_TIPS+1];
    logic [ctf_pkg::MAX_TIPS:0]     hit_link;

    assign col_link[0] = ctrl.col;
    assign hit_link[0] = 1'b0;

    for (genvar i = 0; i < ctf_pkg::MAX_TIPS; i++) begin : g_cell
        ctf_tip_cell u_cell (
            .aclk    (aclk),
            .en      (en[i]),
            .ctrl    (ctrl),
            .col_in  (col_link[i]),
            .hit_in  (hit_link[i]),
            .col_out (col_link[i+1]),
            .hit_out (hit_link[i+1])
        );
    end

    // last cell's column falls off the end; only shifted when the row has room
    assign hit = hit_link[ctf_pkg::MAX_TIPS];

endmodule

>>> hw/rtl/ctf_checker.sv
// Port-level checks for the fingertip finder, bound to the top level.
module ctf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ctf_pkg::M_DATA_BITS-1:0] m_tdata,
    input logic                            m_tuser
);

    localparam int NUM_LO = 2 * ctf_pkg::COORD_BITS;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a dropped tip carries list position zero
    a_drop_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[NUM_LO+ctf_pkg::TIP_NUM_BITS-1:NUM_LO] == '0)
        else $error("dropped tip with nonzero position");

    // padding above the fields stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> ctf_pkg::M_FIELD_BITS) == '0)
        else $error("result padding not zero");

    // squaring cycle follows every accepted point
    a_square_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("point accepted during squaring cycle");

endmodule

bind contour_fingertip_finder_top ctf_checker u_ctf_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the contour fingertip finder: directed and random contours.
`timescale 1ns / 100ps

module tb_top;
    import ctf_pkg::*;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned SINK_HOLD_OFF = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned POINT_TARGET  = 1900;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [COORD_BITS-1:0] DIR_COLS [9] = '{
        12'd0, 12'd4095, 12'd1000, 12'd3000, 12'd2000, 12'd500, 12'd3500, 12'd1500, 12'd2500
    };

    typedef struct {
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
        logic [TIP_NUM_BITS-1:0] num;
        logic                    dropped;
    } tip_t;

    // Predicts fingertips from accepted points and checks what the block emits
    class fingertip_scoreboard;
        logic [COORD_BITS-1:0] centre_x, centre_y, min_gap;
        logic [HOLD_BITS-1:0]  hold_limit;
        logic [DIST_BITS-1:0]  best_dist;
        logic [COORD_BITS-1:0] best_x, best_y;
        logic [HOLD_BITS:0]    hold_cnt;
        int unsigned           tip_cnt;
        logic [COORD_BITS-1:0] tip_cols [MAX_TIPS];
        tip_t                  expected_tips [$];
        int unsigned           mismatches;

        function new();
            centre_x   = '0;
            centre_y   = '0;
            hold_limit = HOLD_LIMIT_RESET;
            min_gap    = MIN_GAP_RESET;
            mismatches = 0;
            clear_contour();
        endfunction

        function void clear_contour();
            best_dist = '0;
            best_x    = '0;
            best_y    = '0;
            hold_cnt  = '0;
            tip_cnt   = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_BITS-1:0] val);
            case (idx)
                CFG_CENTER_X:   centre_x   = val;
                CFG_CENTER_Y:   centre_y   = val;
                CFG_HOLD_LIMIT: hold_limit = val[HOLD_BITS-1:0];
                CFG_MIN_GAP:    min_gap    = val;
                default: ;
            endcase
        endfunction

        function void note_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                 logic first);
            logic [DIST_BITS-1:0]  dx, dy, sq_dist;
            logic [HOLD_BITS:0]    next_cnt;
            logic [COORD_BITS-1:0] col_gap;
            tip_t                  tip;
            if (first)
                clear_contour();
            dx      = (px > centre_x) ? DIST_BITS'(px - centre_x) : DIST_BITS'(centre_x - px);
            dy      = (py > centre_y) ? DIST_BITS'(py - centre_y) : DIST_BITS'(centre_y - py);
            sq_dist = dx * dx + dy * dy;
            if (sq_dist > best_dist) begin
                best_dist = sq_dist;
                best_x    = px;
                best_y    = py;
            end
            if (sq_dist == best_dist)
                return;
            // nine-bit count so a limit of 255 still fires at 256
            next_cnt = hold_cnt + 1'b1;
            if (next_cnt <= {1'b0, hold_limit}) begin
                hold_cnt = next_cnt;
                return;
            end
            hold_cnt  = '0;
            best_dist = '0;
            // held point survives the clear; judge it now
            if (centre_y < best_y)
                return;
            for (int j = 0; j < tip_cnt; j++) begin
                col_gap = (best_x > tip_cols[j]) ? best_x - tip_cols[j] : tip_cols[j] - best_x;
                if (col_gap < min_gap)
                    return;
            end
            tip.x = best_x;
            tip.y = best_y;
            if (tip_cnt < MAX_TIPS) begin
                tip_cols[tip_cnt] = best_x;
                tip.num           = TIP_NUM_BITS'(tip_cnt);
                tip.dropped       = 1'b0;
                tip_cnt++;
            end else begin
                tip.num     = '0;
                tip.dropped = 1'b1;
            end
            expected_tips = {expected_tips, tip};
        endfunction

        function void check_tip(logic [M_DATA_BITS-1:0] data, logic dropped);
            tip_t got, want;
            got.x       = data[COORD_BITS-1:0];
            got.y       = data[2*COORD_BITS-1:COORD_BITS];
            got.num     = data[M_FIELD_BITS-1:2*COORD_BITS];
            got.dropped = dropped;
            if (expected_tips.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected tip: x=%0d y=%0d num=%0d dropped=%0b",
                             got.x, got.y, got.num, got.dropped);
                return;
            end
            want = expected_tips.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.num !== want.num
                    || got.dropped !== want.dropped) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"tip mismatch: exp x=%0d y=%0d num=%0d dropped=%0b, ",
                              "got x=%0d y=%0d num=%0d dropped=%0b"},
                             want.x, want.y, want.num, want.dropped,
                             got.x, got.y, got.num, got.dropped);
            end
        endfunction

        function int unsigned pending();
            return expected_tips.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_DATA_BITS-1:0]  s_tdata;   // point_x, point_y
    logic                    s_tuser;   // first_point
    logic                    cfg_valid;
    logic                    cfg_ready;
    cfg_index_t              cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_DATA_BITS-1:0]  m_tdata;   // tip_x, tip_y, tip_number
    logic                    m_tuser;   // tip_dropped

    fingertip_scoreboard sb = new();

    // Pacing controls for source and sink
    bit          src_no_gaps;
    bit          sink_no_gaps;
    bit          sink_hold_req;
    int unsigned points_sent;
    logic [COORD_BITS-1:0] cur_centre_y;
    logic [HOLD_BITS-1:0]  cur_hold;

    contour_fingertip_finder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Transaction monitor: samples pre-edge values on every rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_point(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS],
                              s_tuser);
            if (m_tvalid && m_tready)
                sb.check_tip(m_tdata, m_tuser);
        end
    end

    // Watchdog: too long with no transaction on any channel ends the run
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result sink: random back-pressure, plus one long hold-off on request
    initial begin : tip_sink
        int unsigned pause;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (sink_hold_req) begin
                // long hold-off so the block fills and stalls its input
                m_tready <= 1'b0;
                repeat (SINK_HOLD_OFF) @(posedge aclk);
                sink_hold_req = 1'b0;
            end
            pause = sink_no_gaps ? 0 : $urandom_range(0, 14);
            if (pause != 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One config register transaction; cfg_valid is left high for the caller
    task automatic put_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes all four registers back to back; block must be idle
    task automatic apply_setting(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                                 input logic [HOLD_BITS-1:0] hold,
                                 input logic [CFG_BITS-1:0] gap);
        put_reg(CFG_CENTER_X, cx);
        put_reg(CFG_CENTER_Y, cy);
        put_reg(CFG_HOLD_LIMIT, CFG_BITS'(hold));
        put_reg(CFG_MIN_GAP, gap);
        cfg_valid    <= 1'b0;
        cur_centre_y = cy;
        cur_hold     = hold;
    endtask

    // Offers one point; s_tvalid stays high after the transaction
    task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                              input logic first);
        int unsigned pause;
        pause = src_no_gaps ? 0 : $urandom_range(0, 14);
        if (pause != 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
    endtask

    // Mostly points above the centre so that tips survive the row check
    task automatic send_contour(input int unsigned len, input bit opens);
        logic [COORD_BITS-1:0] px, py;
        for (int unsigned k = 0; k < len; k++) begin
            px = COORD_BITS'($urandom_range(0, 4095));
            if ($urandom_range(0, 99) < 80)
                py = COORD_BITS'($urandom_range(0, cur_centre_y));
            else
                py = COORD_BITS'($urandom_range(0, 4095));
            send_point(px, py, opens && k == 0);
        end
    endtask

    // Waits for every predicted tip, then lets trailing no-result points finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned           phase_start, budget, len;
        logic [COORD_BITS-1:0] cx, cy;
        logic [HOLD_BITS-1:0]  hold;
        logic [CFG_BITS-1:0]   gap;
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_CENTER_X;
        cfg_data      <= '0;
        src_no_gaps   = 1'b0;
        sink_no_gaps  = 1'b0;
        sink_hold_req = 1'b0;
        points_sent   = 0;
        cur_centre_y  = '0;
        cur_hold      = HOLD_LIMIT_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero hold limit, zero gap, fill the list, one dropped tip,
        // one tip rejected for lying below the centre
        apply_setting(12'd2048, 12'd2048, 8'd0, 12'd0);
        send_point(12'd2048, 12'd2048, 1'b1);
        for (int k = 0; k < 9; k++) begin
            send_point(DIR_COLS[k], 12'd0, 1'b0);
            send_point(12'd2048, 12'd2048, 1'b0);
        end
        send_point(12'd100, 12'd4095, 1'b0);
        send_point(12'd2048, 12'd2048, 1'b0);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < 60 && points_sent < POINT_TARGET; p++) begin
            if (p == 0) begin
                apply_setting(12'd0, 12'd4095, 8'd255, 12'd4095);
                budget = 600;
            end else if (p == 1) begin
                apply_setting(12'd4095, 12'd4095, 8'd1, 12'd0);
                budget = 300;
            end else begin
                cx   = COORD_BITS'($urandom_range(0, 4095));
                cy   = COORD_BITS'($urandom_range(0, 4095));
                hold = ($urandom_range(0, 4) == 0) ? HOLD_BITS'($urandom_range(0, 255))
                                                   : HOLD_BITS'($urandom_range(0, 12));
                case ($urandom_range(0, 2))
                    0:       gap = '0;
                    1:       gap = CFG_BITS'($urandom_range(0, 300));
                    default: gap = CFG_BITS'($urandom_range(0, 4095));
                endcase
                apply_setting(cx, cy, hold, gap);
                budget = 200;
            end
            src_no_gaps  = ($urandom_range(0, 3) == 0);
            sink_no_gaps = ($urandom_range(0, 3) == 0);
            if (p == 1) begin
                // frequent tips, steady source, sink holds off
                src_no_gaps   = 1'b1;
                sink_hold_req = 1'b1;
            end
            phase_start = points_sent;
            while (points_sent - phase_start < budget) begin
                len = $urandom_range(4, 2 * cur_hold + 40);
                // now and then a contour that carries on without a first point
                send_contour(len, $urandom_range(0, 6) != 0);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ctf_pkg.sv
hw/rtl/ctf_dist_unit.sv
hw/rtl/ctf_tip_cell.sv
hw/rtl/ctf_tip_chain.sv
hw/rtl/contour_fingertip_finder_top.sv
hw/rtl/ctf_checker.sv
dv/tb_top.sv
